FILE: src/ray_origin_error_offset_macros.svh
// Assertion macros for the ray origin offset block.
`ifndef RAY_ORIGIN_ERROR_OFFSET_MACROS_SVH
`define RAY_ORIGIN_ERROR_OFFSET_MACROS_SVH

// check cons in the same cycle as ante, outside reset
`define ROEO_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// check cons in the cycle after ante, outside reset
`define ROEO_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

// check cons at every edge, reset included
`define ROEO_ASSERT_ALW(lbl, ck, cons, msg) \
	lbl: assert property (@(posedge ck) (cons)) else $error(msg);

`endif

FILE: src/roeo_pkg.sv
// Types, constants and binary32 arithmetic functions for the ray origin offset block.
package roeo_pkg;

	typedef logic [31:0] f32_t;

	typedef struct packed {
		logic [23:0]        m;
		logic signed [11:0] e;
	} unp_t;

	localparam f32_t CANON_NAN = 32'h7FC0_0000;
	localparam f32_t POS_INF   = 32'h7F80_0000;
	localparam f32_t NEG_INF   = 32'hFF80_0000;
	localparam f32_t SIGN_BIT  = 32'h8000_0000;
	localparam f32_t FP_TWO    = 32'h4000_0000;
	localparam int   SQ_ITER   = 26;
	localparam int   DIV_ITER  = 27;

	function automatic logic f_nan(input f32_t a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic f_inf(input f32_t a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic f_zero(input f32_t a);
		return a[30:0] == 31'd0;
	endfunction

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		n = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		n = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) n = 5'(26 - i);
		end
		return n;
	endfunction

	// normalize a finite nonzero operand: value = m/2^23 * 2^(e-127)
	function automatic unp_t fp_norm(input f32_t a);
		unp_t       u;
		logic [4:0] lz;
		lz = lzc24({1'b0, a[22:0]});
		if (a[30:23] != 8'd0) begin
			u.m = {1'b1, a[22:0]};
			u.e = $signed({4'd0, a[30:23]});
		end else begin
			u.m = {1'b0, a[22:0]} << lz;
			u.e = 12'sd1 - $signed({7'd0, lz});
		end
		return u;
	endfunction

	// round to nearest even: value = m/2^26 * 2^(e-127), m[1:0] sticky
	function automatic f32_t fp_round(input logic s, input logic signed [11:0] e,
			input logic [26:0] m);
		logic signed [11:0] sh;
		logic [26:0]        mm;
		logic [26:0]        lm;
		logic [7:0]         ef;
		logic               inc;
		logic [24:0]        q;
		logic [31:0]        r;
		sh = 12'sd1 - e;
		if (sh > 12'sd27) sh = 12'sd27;
		lm = (27'd1 << sh[4:0]) - 27'd1;
		if (e >= 12'sd255) return {s, 8'hFF, 23'd0};
		if (e <= 12'sd0) begin
			mm = (m >> sh[4:0]) | {26'd0, |(m & lm)};
			ef = 8'd0;
		end else begin
			mm = m;
			ef = e[7:0] - 8'd1;
		end
		inc = mm[2] & (mm[3] | mm[1] | mm[0]);
		q   = {1'b0, mm[26:3]} + {24'd0, inc};
		r   = {1'b0, ef, 23'd0} + {7'd0, q};
		return {s, r[30:0]};
	endfunction

	function automatic f32_t fp_mul(input f32_t a, input f32_t b);
		logic               s;
		unp_t               ua;
		unp_t               ub;
		logic [47:0]        p;
		logic signed [11:0] e;
		logic [26:0]        m;
		s  = a[31] ^ b[31];
		ua = fp_norm(a);
		ub = fp_norm(b);
		p  = ua.m * ub.m;
		e  = ua.e + ub.e - 12'sd127 + $signed({11'd0, p[47]});
		m  = p[47] ? {p[47:22], |p[21:0]} : {p[46:21], |p[20:0]};
		if (f_nan(a) || f_nan(b) || (f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b)))
			return CANON_NAN;
		if (f_inf(a) || f_inf(b)) return {s, POS_INF[30:0]};
		if (f_zero(a) || f_zero(b)) return {s, 31'd0};
		return fp_round(s, e, m);
	endfunction

	function automatic f32_t fp_add(input f32_t a, input f32_t b);
		f32_t               x;
		f32_t               y;
		logic [7:0]         ex;
		logic [7:0]         ey;
		logic [7:0]         d;
		logic [26:0]        am;
		logic [26:0]        bm;
		logic [26:0]        bs;
		logic [26:0]        lmask;
		logic [27:0]        sum;
		logic [26:0]        m;
		logic [4:0]         lz;
		logic signed [11:0] e;
		if (f_nan(a) || f_nan(b)) return CANON_NAN;
		if (f_inf(a) && f_inf(b) && (a[31] != b[31])) return CANON_NAN;
		if (f_inf(a)) return a;
		if (f_inf(b)) return b;
		if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'd0};
		if (f_zero(a)) return b;
		if (f_zero(b)) return a;
		if (b[30:0] > a[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		d  = ex - ey;
		am = {(x[30:23] != 8'd0), x[22:0], 3'b000};
		bm = {(y[30:23] != 8'd0), y[22:0], 3'b000};
		lmask = (27'd1 << d[4:0]) - 27'd1;
		if (d > 8'd26) bs = {26'd0, |bm};
		else bs = (bm >> d[4:0]) | {26'd0, |(bm & lmask)};
		if (x[31] ^ y[31]) sum = {1'b0, am} - {1'b0, bs};
		else sum = {1'b0, am} + {1'b0, bs};
		if (sum == 28'd0) return 32'd0;
		lz = lzc27(sum[26:0]);
		if (sum[27]) begin
			m = {sum[27:2], sum[1] | sum[0]};
			e = $signed({4'd0, ex}) + 12'sd1;
		end else begin
			m = sum[26:0] << lz;
			e = $signed({4'd0, ex}) - $signed({7'd0, lz});
		end
		return fp_round(x[31], e, m);
	endfunction

	function automatic f32_t step_up(input f32_t u);
		if (f_nan(u) || (u == POS_INF)) return u;
		if (u == SIGN_BIT) return 32'd1;
		if (u[31]) return u - 32'd1;
		return u + 32'd1;
	endfunction

	function automatic f32_t step_down(input f32_t u);
		if (f_nan(u) || (u == NEG_INF)) return u;
		if (u == 32'd0) return SIGN_BIT | 32'd1;
		if (u[31]) return u + 32'd1;
		return u - 32'd1;
	endfunction

endpackage

FILE: src/roeo_sqrt.sv
// Pipelined correctly rounded binary32 square root, one result bit per stage.
module roeo_sqrt #(
	parameter int SW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  roeo_pkg::f32_t     x,
	input  logic [SW-1:0]      in_side,
	output logic               out_vld,
	output roeo_pkg::f32_t     root,
	output logic [SW-1:0]      out_side
);
	import roeo_pkg::*;

	localparam int NIT = SQ_ITER;
	localparam int RW  = 2 * SQ_ITER - 1;

	unp_t               u;
	logic signed [11:0] eu;
	logic signed [11:0] hf0;
	logic               sp0;
	f32_t               sv0;
	logic [RW-1:0]      big0;

	logic               v_s   [0:NIT];
	logic [RW-1:0]      big_s [0:NIT];
	logic [RW-1:0]      res_s [0:NIT];
	logic signed [11:0] hf_s  [0:NIT];
	logic               sp_s  [0:NIT];
	f32_t               sv_s  [0:NIT];
	logic [SW-1:0]      sd_s  [0:NIT];

	logic [24:0]        qr;
	logic               inc;
	logic signed [11:0] hfe;
	f32_t               rt;

	always_comb begin
		u  = fp_norm(x);
		eu = u.e - 12'sd127;
		if (eu[0]) begin
			big0 = {27'd0, u.m} << 26;
			hf0  = ((eu - 12'sd49) >>> 1) + 12'sd1;
		end else begin
			big0 = {27'd0, u.m} << 25;
			hf0  = ((eu - 12'sd48) >>> 1) + 12'sd1;
		end
		sp0 = 1'b1;
		if (f_nan(x)) sv0 = CANON_NAN;
		else if (f_zero(x)) sv0 = x;
		else if (x[31]) sv0 = CANON_NAN;
		else if (f_inf(x)) sv0 = x;
		else begin
			sp0 = 1'b0;
			sv0 = x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s[0] <= big0;
			res_s[0] <= '0;
			hf_s[0]  <= hf0;
			sp_s[0]  <= sp0;
			sv_s[0]  <= sv0;
			sd_s[0]  <= in_side;
		end
	end

	for (genvar k = 0; k < NIT; k++) begin : g_it
		localparam logic [RW-1:0] BITV = {{(RW-1){1'b0}}, 1'b1} << (2 * (NIT - 1 - k));
		logic [RW-1:0] trial;
		logic [RW-1:0] nb;
		logic [RW-1:0] nr;
		logic          ge;

		always_comb begin
			trial = res_s[k] + BITV;
			ge    = big_s[k] >= trial;
			nb    = ge ? big_s[k] - trial : big_s[k];
			nr    = ge ? (res_s[k] >> 1) + BITV : res_s[k] >> 1;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				big_s[k+1] <= nb;
				res_s[k+1] <= nr;
				hf_s[k+1]  <= hf_s[k];
				sp_s[k+1]  <= sp_s[k];
				sv_s[k+1]  <= sv_s[k];
				sd_s[k+1]  <= sd_s[k];
			end
		end
	end

	always_comb begin
		inc = res_s[NIT][0] & ((big_s[NIT] != '0) | res_s[NIT][1]);
		qr  = {1'b0, res_s[NIT][24:1]} + {24'd0, inc};
		hfe = qr[24] ? hf_s[NIT] + 12'sd1 : hf_s[NIT];
		rt  = {1'b0, 8'(hfe + 12'sd150), qr[24] ? 23'd0 : qr[22:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else if (en) out_vld <= v_s[NIT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root     <= sp_s[NIT] ? sv_s[NIT] : rt;
			out_side <= sd_s[NIT];
		end
	end

endmodule

FILE: src/roeo_div.sv
// Pipelined three-lane binary32 divider by a shared positive divisor, one quotient bit per stage.
module roeo_div #(
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  roeo_pkg::f32_t [2:0] num,
	input  roeo_pkg::f32_t       den,
	input  logic [SW-1:0]        in_side,
	output logic                 out_vld,
	output roeo_pkg::f32_t [2:0] quo,
	output logic [SW-1:0]        out_side
);
	import roeo_pkg::*;

	localparam int NIT = DIV_ITER;

	unp_t               ub;
	unp_t               ua  [0:2];
	logic signed [11:0] e0  [0:2];
	logic [2:0]         sp0;
	f32_t [2:0]         sv0;

	logic               v_s   [0:NIT];
	logic [24:0]        rem_s [0:NIT][0:2];
	logic [26:0]        qb_s  [0:NIT][0:2];
	logic signed [11:0] ex_s  [0:NIT][0:2];
	logic [23:0]        mb_s  [0:NIT];
	logic [2:0]         sg_s  [0:NIT];
	logic [2:0]         sp_s  [0:NIT];
	f32_t [2:0]         sv_s  [0:NIT];
	logic [SW-1:0]      sd_s  [0:NIT];

	f32_t [2:0]         qv;
	logic [26:0]        fm  [0:2];
	logic signed [11:0] fe  [0:2];

	always_comb begin
		ub = fp_norm(den);
		for (int l = 0; l < 3; l++) begin
			ua[l]  = fp_norm(num[l]);
			e0[l]  = ua[l].e - ub.e + 12'sd127;
			sp0[l] = 1'b1;
			if (f_nan(num[l]) || f_nan(den)) sv0[l] = CANON_NAN;
			else if (f_zero(den))
				sv0[l] = f_zero(num[l]) ? CANON_NAN : {num[l][31], POS_INF[30:0]};
			else if (f_inf(den)) sv0[l] = f_inf(num[l]) ? CANON_NAN : {num[l][31], 31'd0};
			else if (f_inf(num[l])) sv0[l] = {num[l][31], POS_INF[30:0]};
			else if (f_zero(num[l])) sv0[l] = {num[l][31], 31'd0};
			else begin
				sp0[l] = 1'b0;
				sv0[l] = num[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= {1'b0, ua[l].m};
				qb_s[0][l]  <= '0;
				ex_s[0][l]  <= e0[l];
				sg_s[0][l]  <= num[l][31];
			end
			mb_s[0] <= ub.m;
			sp_s[0] <= sp0;
			sv_s[0] <= sv0;
			sd_s[0] <= in_side;
		end
	end

	for (genvar k = 0; k < NIT; k++) begin : g_it
		logic [24:0] nr [0:2];
		logic [2:0]  ge;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				ge[l] = rem_s[k][l] >= {1'b0, mb_s[k]};
				nr[l] = (ge[l] ? rem_s[k][l] - {1'b0, mb_s[k]} : rem_s[k][l]) << 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					rem_s[k+1][l] <= nr[l];
					qb_s[k+1][l]  <= {qb_s[k][l][25:0], ge[l]};
					ex_s[k+1][l]  <= ex_s[k][l];
				end
				mb_s[k+1] <= mb_s[k];
				sg_s[k+1] <= sg_s[k];
				sp_s[k+1] <= sp_s[k];
				sv_s[k+1] <= sv_s[k];
				sd_s[k+1] <= sd_s[k];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (qb_s[NIT][l][26]) begin
				fm[l] = {qb_s[NIT][l][26:1], qb_s[NIT][l][0] | (rem_s[NIT][l] != 25'd0)};
				fe[l] = ex_s[NIT][l];
			end else begin
				fm[l] = {qb_s[NIT][l][25:0], rem_s[NIT][l] != 25'd0};
				fe[l] = ex_s[NIT][l] - 12'sd1;
			end
			qv[l] = sp_s[NIT][l] ? sv_s[NIT][l] : fp_round(sg_s[NIT][l], fe[l], fm[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else if (en) out_vld <= v_s[NIT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo      <= qv;
			out_side <= sd_s[NIT];
		end
	end

endmodule

FILE: src/ray_origin_error_offset.sv
// Top level of the ray origin offset pipeline: offsets a hit point along its normal by the error bound.
//
// channel  dir  bits  words carry
// s_axis   in   384   pos xyz, err xyz, normal xyz, dir xyz
// m_axis   out  96    origin xyz
//
// One word enters per cycle while the output is not stalled.
// Most of the pipeline lies in the 26-stage square root and the 27-stage quotient chain.
// Reset clears the valid bits only.
// A held output word stalls every stage at once; s_axis_tready drops with it.
module ray_origin_error_offset (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x, pos_y, pos_z, err_x, err_y, err_z, normal_x, normal_y, normal_z, dir_x, dir_y, dir_z
	input  logic [383:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// origin_x, origin_y, origin_z
	output logic [95:0]  m_axis_tdata
);
	import roeo_pkg::*;

	localparam int SQ_SW = 1 + 9 * 32;
	localparam int DV_SW = 1 + 6 * 32;

	logic       en;
	f32_t [2:0] pos;
	f32_t [2:0] err;
	f32_t [2:0] nrm;
	f32_t [2:0] dir;

	logic       v_s1;
	f32_t [2:0] wn_s1, nq_s1, pos_s1, err_s1, nrm_s1;
	logic       v_s2;
	f32_t       dot_s2, nsq_s2, wn2_s2, nq2_s2;
	f32_t [2:0] pos_s2, err_s2, nrm_s2;
	logic       v_s3;
	f32_t       nsq_s3;
	logic       dneg_s3;
	f32_t [2:0] pos_s3, err_s3, nrm_s3;
	f32_t       dsum;

	logic             sq_vld;
	f32_t             len;
	logic [SQ_SW-1:0] sq_side;
	f32_t [2:0]       sq_pos, sq_err, sq_nrm;
	logic             sq_dneg;

	logic             dv_vld;
	f32_t [2:0]       quo;
	logic [DV_SW-1:0] dv_side;
	f32_t [2:0]       dv_pos, dv_err;
	logic             dv_dneg;

	logic       v_s4;
	f32_t [2:0] nn_s4, a_s4, pos_s4;
	logic       v_s5;
	f32_t       d01_s5, a2_s5;
	f32_t [2:0] nn_s5, pos_s5;
	logic       v_s6;
	f32_t       d_s6;
	f32_t [2:0] nn_s6, pos_s6;
	logic       v_s7;
	f32_t [2:0] off_s7, pos_s7;
	logic       v_s8;
	f32_t [2:0] tw_s8, pos_s8;
	logic [2:0] up_s8, dn_s8;
	logic       v_s9;
	f32_t [2:0] o_s9;
	logic [2:0] up_s9, dn_s9;
	logic       v_s10;
	f32_t [2:0] out_s10;
	f32_t [2:0] fin;

	assign en            = !v_s10 || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = v_s10;
	assign m_axis_tdata  = out_s10;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos[i] = s_axis_tdata[32*i +: 32];
			err[i] = s_axis_tdata[96 + 32*i +: 32];
			nrm[i] = s_axis_tdata[192 + 32*i +: 32];
			dir[i] = s_axis_tdata[288 + 32*i +: 32];
		end
	end

	always_comb begin
		dsum = fp_add(dot_s2, wn2_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= s_axis_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= dv_vld;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				wn_s1[i] <= fp_mul(dir[i], nrm[i]);
				nq_s1[i] <= fp_mul(nrm[i], nrm[i]);
			end
			pos_s1 <= pos;
			err_s1 <= err;
			nrm_s1 <= nrm;

			dot_s2 <= fp_add(wn_s1[0], wn_s1[1]);
			nsq_s2 <= fp_add(nq_s1[0], nq_s1[1]);
			wn2_s2 <= wn_s1[2];
			nq2_s2 <= nq_s1[2];
			pos_s2 <= pos_s1;
			err_s2 <= err_s1;
			nrm_s2 <= nrm_s1;

			nsq_s3  <= fp_add(nsq_s2, nq2_s2);
			dneg_s3 <= f_nan(dsum) || (dsum[31] && !f_zero(dsum));
			pos_s3  <= pos_s2;
			err_s3  <= err_s2;
			nrm_s3  <= nrm_s2;
		end
	end

	roeo_sqrt #(
		.SW(SQ_SW)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (v_s3),
		.x       (nsq_s3),
		.in_side ({dneg_s3, nrm_s3, err_s3, pos_s3}),
		.out_vld (sq_vld),
		.root    (len),
		.out_side(sq_side)
	);

	assign sq_pos  = sq_side[95:0];
	assign sq_err  = sq_side[191:96];
	assign sq_nrm  = sq_side[287:192];
	assign sq_dneg = sq_side[288];

	roeo_div #(
		.SW(DV_SW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.num     (sq_nrm),
		.den     (len),
		.in_side ({sq_dneg, sq_err, sq_pos}),
		.out_vld (dv_vld),
		.quo     (quo),
		.out_side(dv_side)
	);

	assign dv_pos  = dv_side[95:0];
	assign dv_err  = dv_side[191:96];
	assign dv_dneg = dv_side[192];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (up_s9[i]) fin[i] = step_up(o_s9[i]);
			else if (dn_s9[i]) fin[i] = step_down(o_s9[i]);
			else fin[i] = o_s9[i];
			if (f_nan(fin[i])) fin[i] = CANON_NAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nn_s4[i] <= quo[i] ^ {dv_dneg, 31'd0};
				a_s4[i]  <= fp_mul({1'b0, quo[i][30:0]}, dv_err[i]);
			end
			pos_s4 <= dv_pos;

			d01_s5 <= fp_add(a_s4[0], a_s4[1]);
			a2_s5  <= a_s4[2];
			nn_s5  <= nn_s4;
			pos_s5 <= pos_s4;

			d_s6   <= fp_add(d01_s5, a2_s5);
			nn_s6  <= nn_s5;
			pos_s6 <= pos_s5;

			for (int i = 0; i < 3; i++) begin
				off_s7[i] <= fp_mul(d_s6, nn_s6[i]);
				tw_s8[i]  <= fp_mul(off_s7[i], FP_TWO);
				up_s8[i]  <= !f_nan(off_s7[i]) && !f_zero(off_s7[i]) && !off_s7[i][31];
				dn_s8[i]  <= !f_nan(off_s7[i]) && !f_zero(off_s7[i]) && off_s7[i][31];
				o_s9[i]   <= fp_add(pos_s8[i], tw_s8[i]);
			end
			pos_s7 <= pos_s6;
			pos_s8 <= pos_s7;
			up_s9  <= up_s8;
			dn_s9  <= dn_s8;

			out_s10 <= fin;
		end
	end

endmodule

FILE: src/roeo_checker.sv
// Port checker for the ray origin offset block, bound to the top level.
`include "ray_origin_error_offset_macros.svh"

module roeo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata
);
	logic [2:0] bad_nan;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bad_nan[i] = (m_axis_tdata[32*i+23 +: 8] == 8'hFF) &&
				(m_axis_tdata[32*i +: 23] != 23'd0) &&
				(m_axis_tdata[32*i +: 32] != 32'h7FC0_0000);
		end
	end

	`ROEO_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
	`ROEO_ASSERT_IMP(a_ready, clk, arst_n, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")
	`ROEO_ASSERT_NXT(a_rst, clk, 1'b1, !arst_n, !m_axis_tvalid, "output valid during reset")
	`ROEO_ASSERT_IMP(a_nan, clk, arst_n, m_axis_tvalid, bad_nan == 3'd0, "non-canonical NaN on output")

endmodule

bind ray_origin_error_offset roeo_checker u_roeo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
